FILE: sv/gbp_pkg.sv
// Shared types and constants for the gshare branch predictor.
// No dependencies; the top level imports this package.
package gbp_pkg;

	localparam int unsigned IDX_W       = 10;
	localparam int unsigned CNT_W       = 2;
	localparam int unsigned TABLE_DEPTH = 1024;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t CNT_RESET = 2'd1;
	localparam cnt_t CNT_MAX   = 2'd3;
	localparam cnt_t CNT_MIN   = 2'd0;

	localparam logic FUNC_PREDICT = 1'b0;
	localparam logic FUNC_UPDATE  = 1'b1;

endpackage

FILE: sv/gbp_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// A read at the address being written returns the old contents. No dependencies.
module gbp_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/gshare_branch_predictor_unit.sv
// Gshare predictor: 1024 two-bit counters indexed by pc XOR global history.
// Results pass through stage 1 and then the output registers; one item per cycle unless in_stall is high.
// The registered counter RAM read feeds the update stage, with a one-entry bypass
// for a write to the same index in the cycle of the read.
// After reset, a clearing pass writes every counter to weakly not taken while in_stall
// is held high. History resets to zero. Depends on gbp_pkg and gbp_ram.
module gshare_branch_predictor_unit #(
	parameter int unsigned HISTORY_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  gbp_pkg::idx_t       pc,
	input  gbp_pkg::idx_t       index,
	input  logic                taken,
	output logic                out_valid,
	input  logic                out_stall,
	output gbp_pkg::idx_t       table_index,
	output gbp_pkg::cnt_t       counter_value,
	output logic                predict_taken
);

	import gbp_pkg::*;

	logic [HISTORY_BITS-1:0] hist_q;
	idx_t                    hist_lo;

	logic clr_busy_q;
	idx_t clr_cnt_q;

	logic valid_s1;
	logic func_s1;
	idx_t idx_s1;
	logic taken_s1;
	logic byp_s1;
	cnt_t byp_val_s1;

	logic in_accept;
	logic s1_adv;
	idx_t rd_addr;
	cnt_t rd_data;
	cnt_t cur_cnt;
	cnt_t new_cnt;
	cnt_t res_cnt;
	logic upd_we;
	logic ram_we;
	idx_t ram_waddr;
	cnt_t ram_wdata;

	// Only the low index bits of history enter the hash.
	generate
		if (HISTORY_BITS >= IDX_W) begin : g_hist_wide
			assign hist_lo = hist_q[IDX_W-1:0];
		end else begin : g_hist_narrow
			assign hist_lo = {{(IDX_W-HISTORY_BITS){1'b0}}, hist_q};
		end
	endgenerate

	assign s1_adv    = !out_valid || !out_stall;
	assign in_stall  = clr_busy_q || (valid_s1 && !s1_adv);
	assign in_accept = in_valid && !in_stall;
	assign rd_addr   = (func == FUNC_UPDATE) ? index : (hist_lo ^ pc);

	assign cur_cnt = byp_s1 ? byp_val_s1 : rd_data;

	always_comb begin
		if (taken_s1) begin
			new_cnt = (cur_cnt == CNT_MAX) ? CNT_MAX : cur_cnt + 2'd1;
		end else begin
			new_cnt = (cur_cnt == CNT_MIN) ? CNT_MIN : cur_cnt - 2'd1;
		end
	end

	assign res_cnt   = (func_s1 == FUNC_UPDATE) ? new_cnt : cur_cnt;
	assign upd_we    = valid_s1 && s1_adv && (func_s1 == FUNC_UPDATE);
	assign ram_we    = clr_busy_q || upd_we;
	assign ram_waddr = clr_busy_q ? clr_cnt_q : idx_s1;
	assign ram_wdata = clr_busy_q ? CNT_RESET : new_cnt;

	gbp_ram #(
		.WIDTH(CNT_W),
		.DEPTH(TABLE_DEPTH)
	) u_cnt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (in_accept),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			hist_q     <= '0;
			valid_s1   <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == idx_t'(TABLE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end

			// Shift history at accept so a following predict hashes with it.
			if (in_accept && func == FUNC_UPDATE) begin
				hist_q <= {hist_q[HISTORY_BITS-2:0], taken};
			end

			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end

			if (valid_s1 && s1_adv) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1    <= func;
			idx_s1     <= rd_addr;
			taken_s1   <= taken;
			// Read returns old data when the same entry is written this cycle.
			byp_s1     <= upd_we && (idx_s1 == rd_addr);
			byp_val_s1 <= new_cnt;
		end
		if (valid_s1 && s1_adv) begin
			table_index   <= idx_s1;
			counter_value <= res_cnt;
			predict_taken <= res_cnt[CNT_W-1];
		end
	end

endmodule

FILE: tb/sv/gshare_checker.sv
`timescale 1ns / 1ps
// Checker for the gshare branch predictor: watches both channels, keeps its own
// history and counter table, and compares each result with the oldest pending lookup.
// Depends on gbp_pkg.
module gshare_checker #(
	parameter int unsigned HISTORY_BITS = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  logic           func,
	input  gbp_pkg::idx_t  pc,
	input  gbp_pkg::idx_t  index,
	input  logic           taken,
	input  logic           out_valid,
	input  logic           out_stall,
	input  gbp_pkg::idx_t  table_index,
	input  gbp_pkg::cnt_t  counter_value,
	input  logic           predict_taken,
	output int             fail_count,
	output int             outstanding
);
	import gbp_pkg::*;

	typedef struct packed {
		idx_t tidx;
		cnt_t cnt;
		logic tk;
	} lookup_t;

	lookup_t                 pending_lookups[$];
	cnt_t                    counters[TABLE_DEPTH];
	logic [HISTORY_BITS-1:0] ghist;
	lookup_t                 want;
	lookup_t                 got;
	int                      errors = 0;

	function automatic cnt_t saturate_step(input cnt_t c, input logic up);
		if (up)
			return (c == CNT_MAX) ? CNT_MAX : cnt_t'(c + 1'b1);
		return (c == CNT_MIN) ? CNT_MIN : cnt_t'(c - 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist = '0;
			foreach (counters[i])
				counters[i] = CNT_RESET;
			pending_lookups.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			// retire first: an item accepted this edge cannot have its result yet
			if (out_valid && !out_stall) begin
				got = '{table_index, counter_value, predict_taken};
				if (pending_lookups.size() == 0) begin
					$display("%0t: unexpected result index=%0d counter=%0d taken=%0b",
						$time, got.tidx, got.cnt, got.tk);
					errors++;
				end else begin
					want = pending_lookups.pop_front();
					if (got.tidx !== want.tidx) begin
						$display("%0t: table_index expected %0d actual %0d",
							$time, want.tidx, got.tidx);
						errors++;
					end
					if (got.cnt !== want.cnt) begin
						$display("%0t: counter_value expected %0d actual %0d (index %0d)",
							$time, want.cnt, got.cnt, want.tidx);
						errors++;
					end
					if (got.tk !== want.tk) begin
						$display("%0t: predict_taken expected %0b actual %0b (index %0d)",
							$time, want.tk, got.tk, want.tidx);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (func == FUNC_PREDICT) begin
					// history narrower than the index leaves the upper hash bits to pc
					want.tidx = pc ^ idx_t'(ghist);
					want.cnt  = counters[want.tidx];
				end else begin
					want.tidx = index;
					want.cnt  = saturate_step(counters[index], taken);
					counters[index] = want.cnt;
					ghist = {ghist[HISTORY_BITS-2:0], taken};
				end
				want.tk = want.cnt[1];
				pending_lookups.push_back(want);
			end
			outstanding <= pending_lookups.size();
			fail_count  <= errors;
		end
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the gshare predictor testbench: clock, reset, branch-trace stimulus,
// result-side stalls, watchdog and verdict. Depends on gbp_pkg, gshare_checker
// and gshare_branch_predictor_unit.
module tb;
	import gbp_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int NUM_ITEMS   = 1550;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 200;

	logic  clk           = 1'b0;
	logic  arst_n        = 1'b0;
	logic  in_valid      = 1'b0;
	logic  in_stall;
	logic  func          = FUNC_PREDICT;
	idx_t  pc            = '0;
	idx_t  index         = '0;
	logic  taken         = 1'b0;
	logic  out_valid;
	logic  out_stall     = 1'b0;
	idx_t  table_index;
	cnt_t  counter_value;
	logic  predict_taken;

	int    fail_count;
	int    outstanding;
	int    items_sent    = 0;
	int    quiet_cycles  = 0;
	bit    tx_idle       = 1'b1;
	bit    rx_idle       = 1'b1;
	bit    long_hold     = 1'b0;
	idx_t  outcome_trail = '0;
	idx_t  hot_slots[32];

	always #(CLK_PERIOD / 2) clk = ~clk;

	gshare_branch_predictor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.pc            (pc),
		.index         (index),
		.taken         (taken),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.table_index   (table_index),
		.counter_value (counter_value),
		.predict_taken (predict_taken)
	);

	gshare_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.pc            (pc),
		.index         (index),
		.taken         (taken),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.table_index   (table_index),
		.counter_value (counter_value),
		.predict_taken (predict_taken),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	// Offer one item and return at the edge that accepts it.
	task automatic send_item(input logic f, input idx_t p, input idx_t ix, input logic t);
		int gap;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		pc       <= p;
		index    <= ix;
		taken    <= t;
		do @(posedge clk); while (in_stall);
		if (f == FUNC_UPDATE)
			outcome_trail = {outcome_trail[IDX_W-2:0], t};
		items_sent++;
	endtask

	// Hold the input until every result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// One branch: look it up, then resolve it. Most branches aim at a small hot set
	// so counters walk to both ends; a few lone items add noise.
	task automatic run_branch();
		int   k;
		idx_t ix;
		logic dir;
		logic t;
		k = $urandom_range(0, 31);
		if ($urandom_range(0, 9) < 7) begin
			ix  = hot_slots[k];
			dir = k[0];
		end else begin
			ix  = idx_t'($urandom);
			dir = 1'($urandom_range(0, 1));
		end
		send_item(FUNC_PREDICT, ix ^ outcome_trail, idx_t'($urandom), 1'($urandom));
		if ($urandom_range(0, 9) == 0)
			send_item(1'($urandom), idx_t'($urandom), idx_t'($urandom), 1'($urandom));
		t = ($urandom_range(0, 9) < 8) ? dir : ~dir;
		send_item(FUNC_UPDATE, idx_t'($urandom), ix, t);
	endtask

	// Receiver: a random stall before each result, and one long hold on request.
	initial begin
		int n;
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end
			n = rx_idle ? $urandom_range(0, 12) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int phase;
		foreach (hot_slots[i])
			hot_slots[i] = idx_t'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// extremes of pc, saturation at both ends, history steering the hash
		send_item(FUNC_PREDICT, '0, '1, 1'b1);
		send_item(FUNC_PREDICT, '1, '0, 1'b0);
		repeat (3) send_item(FUNC_UPDATE, '1, '0, 1'b1);
		repeat (2) send_item(FUNC_UPDATE, '0, '1, 1'b0);
		send_item(FUNC_PREDICT, 10'h01C, '0, 1'b0);
		send_item(FUNC_PREDICT, 10'h3E3, '0, 1'b0);
		repeat (4) send_item(FUNC_UPDATE, 10'h2AA, '0, 1'b0);
		repeat (10) send_item(FUNC_UPDATE, '0, 10'h155, 1'b1);
		send_item(FUNC_PREDICT, '0, 10'h155, 1'b1);

		phase = 0;
		while (items_sent < NUM_ITEMS) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				// keep offering while the result side is held off
				tx_idle   = 1'b0;
				long_hold = 1'b1;
			end
			if (phase == 4)
				drain_results();
			repeat (40) run_branch();
			phase++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
